[hdl/ned_pkg.sv]
// ----------------------------------------------------------------------------
// ned_pkg
// Shared types, codes and helpers for the 3x3 neighborhood edge detector.
// ----------------------------------------------------------------------------
`default_nettype none
package ned_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int PIX_W = 24;
	localparam int THR_W = 8;
	localparam int CFG_WIDTH_W = 11;
	localparam int CFG_HEIGHT_W = 16;
	localparam int ROW_W = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_WIDTH_W-1:0] RST_WIDTH = 11'd640;
	localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = 16'd480;
	localparam logic [THR_W-1:0] RST_THRESHOLD = 8'd0;

	localparam logic [PIX_W-1:0] WHITE_PIXEL = 24'hFFFFFF;
	localparam logic [PIX_W-1:0] BLACK_PIXEL = 24'h000000;

	// Item kinds on the input stream.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WIDTH = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// One window column plus the answer bookkeeping for the back end.
	typedef struct packed {
		logic             emit;
		logic             last;
		logic             ok_r0;
		logic             ok_r2;
		logic             ok_c0;
		logic             ok_c2;
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} item_t;

	// Largest absolute channel difference between two RGB pixels.
	function automatic logic [7:0] pix_dist(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [7:0] d;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] m;
		m = 8'd0;
		for (int c = 0; c < 3; c++) begin
			x = a[c*8 +: 8];
			y = b[c*8 +: 8];
			d = (x > y) ? (x - y) : (y - x);
			if (d > m) m = d;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

[hdl/ned_front.sv]
// ----------------------------------------------------------------------------
// ned_front
// Accepts pixel and flush items, tracks frame positions and the pending count,
// and reads and writes the two line stores to form one window column per pixel and per flush with a pixel pending.
// ----------------------------------------------------------------------------
`default_nettype none
module ned_front #(
	parameter int MAX_WIDTH = ned_pkg::DEF_MAX_WIDTH
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              in_cmd,
	input  wire  [ned_pkg::PIX_W-1:0]        in_pixel,
	input  wire  [ned_pkg::CFG_WIDTH_W-1:0]  width_cfg,
	input  wire  [ned_pkg::CFG_HEIGHT_W-1:0] height_cfg,
	output ned_pkg::item_t                   q_item,
	output logic                             q_valid,
	input  wire                              q_ready
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int RW = ned_pkg::ROW_W;

	logic [WW-1:0] w_eff;
	logic [RW-1:0] h_eff;
	logic [CW-1:0] col_q, ecol_q, rd_addr, col_nxt, ecol_nxt;
	logic [RW-1:0] row_q, erow_q, row_nxt, erow_nxt;
	logic [PW-1:0] pend_q;
	logic          is_pix, pend_nz, emit, do_shift, in_fire, push, fwd;
	logic          col_end, ok_r0, ok_r2, ok_c0, ok_c2, last;

	logic [ned_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [ned_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];

	logic                      v_s1, wr_s1, emit_s1, last_s1;
	logic                      ok_r0_s1, ok_r2_s1, ok_c0_s1, ok_c2_s1;
	logic [CW-1:0]             addr_s1;
	logic [ned_pkg::PIX_W-1:0] up_s1, mid_s1, bot_s1;

	// Effective geometry: zero width or height acts as one, width saturates.
	always_comb begin
		if (width_cfg == '0) w_eff = WW'(1);
		else if (32'(width_cfg) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(width_cfg);
		h_eff = (height_cfg == '0) ? RW'(1) : height_cfg;
	end

	// Classification and the position of the oldest pending pixel.
	always_comb begin
		is_pix   = (in_cmd == ned_pkg::CMD_PIXEL);
		pend_nz  = (pend_q != '0);
		emit     = is_pix ? (32'(pend_q) >= 32'(w_eff) + 1) : pend_nz;
		do_shift = is_pix || pend_nz;
		ok_r0    = (erow_q != '0);
		ok_r2    = (32'(erow_q) + 1 < 32'(h_eff));
		ok_c0    = (ecol_q != '0);
		ok_c2    = (32'(ecol_q) + 1 < 32'(w_eff));
		last     = (32'(erow_q) + 1 == 32'(h_eff)) && (32'(ecol_q) + 1 == 32'(w_eff));
		ecol_nxt = ok_c2 ? CW'(32'(ecol_q) + 1) : '0;
		erow_nxt = ok_c2 ? erow_q : (ok_r2 ? erow_q + RW'(1) : '0);
		col_end  = (32'(col_q) + 1 >= 32'(w_eff));
		col_nxt  = col_end ? '0 : CW'(32'(col_q) + 1);
		row_nxt  = col_end ? ((32'(row_q) + 1 >= 32'(h_eff)) ? '0 : row_q + RW'(1)) : row_q;
		rd_addr  = is_pix ? col_q : ecol_nxt;
	end

	assign push     = v_s1 && q_ready;
	assign in_ready = !v_s1 || q_ready;
	assign in_fire  = in_valid && in_ready;
	assign fwd      = push && wr_s1 && (addr_s1 == rd_addr);

	// Frame position, answer position and pending count.
	// A pixel at or past the end of a row is answered as the last column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ecol_q <= '0;
			erow_q <= '0;
			pend_q <= '0;
		end else if (in_fire) begin
			if (is_pix) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
				if (!pend_nz) begin
					ecol_q <= col_end ? CW'(32'(w_eff) - 1) : col_q;
					erow_q <= (col_end && (32'(row_q) + 1 >= 32'(h_eff))) ?
						h_eff - RW'(1) : row_q;
				end
				pend_q <= emit ? PW'(32'(w_eff) + 1) : pend_q + PW'(1);
			end else if (pend_nz) begin
				pend_q <= pend_q - PW'(1);
			end
			if (emit) begin
				ecol_q <= ecol_nxt;
				erow_q <= erow_nxt;
			end
		end
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= do_shift;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	// Line stores: registered read with a bypass from the column being written.
	always_ff @(posedge clk) begin
		if (push && wr_s1) begin
			upper_mem[addr_s1]  <= mid_s1;
			middle_mem[addr_s1] <= bot_s1;
		end
		if (in_fire) begin
			if (fwd) begin
				up_s1  <= mid_s1;
				mid_s1 <= bot_s1;
			end else begin
				up_s1  <= upper_mem[rd_addr];
				mid_s1 <= middle_mem[rd_addr];
			end
			wr_s1    <= is_pix;
			addr_s1  <= rd_addr;
			bot_s1   <= is_pix ? in_pixel : '0;
			emit_s1  <= emit;
			last_s1  <= last;
			ok_r0_s1 <= ok_r0;
			ok_r2_s1 <= ok_r2;
			ok_c0_s1 <= ok_c0;
			ok_c2_s1 <= ok_c2;
		end
	end

	assign q_valid = v_s1;
	always_comb begin
		q_item.emit  = emit_s1;
		q_item.last  = last_s1;
		q_item.ok_r0 = ok_r0_s1;
		q_item.ok_r2 = ok_r2_s1;
		q_item.ok_c0 = ok_c0_s1;
		q_item.ok_c2 = ok_c2_s1;
		q_item.up    = up_s1;
		q_item.mid   = mid_s1;
		q_item.bot   = bot_s1;
	end

endmodule
`default_nettype wire

[hdl/ned_queue.sv]
// ----------------------------------------------------------------------------
// ned_queue
// Short first-in first-out queue of window columns between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module ned_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_valid,
	output logic            s_ready,
	input  ned_pkg::item_t  s_item,
	output logic            m_valid,
	input  wire             m_ready,
	output ned_pkg::item_t  m_item
);

	localparam int AW = $clog2(ned_pkg::QUEUE_DEPTH);

	ned_pkg::item_t mem_q [ned_pkg::QUEUE_DEPTH];
	logic [AW-1:0]  wptr_q, rptr_q;
	logic [AW:0]    cnt_q;
	logic           wr, rd;

	assign s_ready = (32'(cnt_q) < ned_pkg::QUEUE_DEPTH);
	assign m_valid = (cnt_q != '0);
	assign wr      = s_valid && s_ready;
	assign rd      = m_valid && m_ready;
	assign m_item  = mem_q[rptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + AW'(1);
			if (rd) rptr_q <= rptr_q + AW'(1);
			if (wr && !rd) cnt_q <= cnt_q + (AW+1)'(1);
			else if (rd && !wr) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= s_item;
	end

endmodule
`default_nettype wire

[hdl/ned_back.sv]
// ----------------------------------------------------------------------------
// ned_back
// Shifts columns into the 3x3 window, compares the center with its in-bounds
// neighbors and holds the answer in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module ned_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        q_valid,
	output logic                       q_ready,
	input  ned_pkg::item_t             q_item,
	input  wire  [ned_pkg::THR_W-1:0]  threshold,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic                       out_edge,
	output logic [ned_pkg::PIX_W-1:0]  out_pixel,
	output logic                       out_last
);

	logic [ned_pkg::PIX_W-1:0] win_q [3][3];
	logic       v_s1, last_s1;
	logic [2:0] okr_s1, okc_s1;
	logic       pop, s1_hold, load, edge_hit;

	assign s1_hold = v_s1 && out_valid && !out_ready;
	assign q_ready = !s1_hold;
	assign pop     = q_valid && q_ready;
	assign load    = v_s1 && !s1_hold;

	// Window shift and answer flags; only emitting columns keep the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
			end
		end else if (pop) begin
			v_s1 <= q_item.emit;
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= q_item.up;
			win_q[1][2] <= q_item.mid;
			win_q[2][2] <= q_item.bot;
		end else if (load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			last_s1 <= q_item.last;
			okr_s1  <= {q_item.ok_r2, 1'b1, q_item.ok_r0};
			okc_s1  <= {q_item.ok_c2, 1'b1, q_item.ok_c0};
		end
	end

	// Nine distance compares against the center pixel.
	always_comb begin
		edge_hit = 1'b0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (okr_s1[r] && okc_s1[c] &&
					(ned_pkg::pix_dist(win_q[1][1], win_q[r][c]) > threshold))
					edge_hit = 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_edge  <= edge_hit;
			out_pixel <= edge_hit ? ned_pkg::BLACK_PIXEL : ned_pkg::WHITE_PIXEL;
			out_last  <= last_s1;
		end
	end

endmodule
`default_nettype wire

[hdl/neighborhood_edge_detect_core.sv]
// ----------------------------------------------------------------------------
// neighborhood_edge_detect_core
// 3x3 maximum-difference edge detector on a raster stream of RGB pixels.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_*       in         tuser: command; tdata: pixel_rgb
// m_*       out        tdata: edge_found, out_pixel; tlast: last_of_frame
// cfg_*     in         cfg_index selects the register, cfg_data is the value
//
// One item per clock sustained while the result side does not stall; an answer that an
// item releases passes the line-store read, the queue, the window and the output register.
// Results lag the input by one row plus one pixel; flush items drain them.
// Reset clears counters, window and configuration; line stores are not cleared.
// Either side may stall on its own; the queue absorbs short back-end stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module neighborhood_edge_detect_core #(
	parameter int MAX_WIDTH = ned_pkg::DEF_MAX_WIDTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // [23:0] pixel_rgb
	input  wire  [0:0]  s_tuser,   // [0] command
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [0] edge_found, [24:1] out_pixel, rest zero
	output logic        m_tlast,   // last_of_frame
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	logic [ned_pkg::THR_W-1:0]        thr_q;
	logic [ned_pkg::CFG_WIDTH_W-1:0]  width_q;
	logic [ned_pkg::CFG_HEIGHT_W-1:0] height_q;

	ned_pkg::item_t            f_item, b_item;
	logic                      f_valid, f_ready, b_valid, b_ready;
	logic                      o_edge, o_last;
	logic [ned_pkg::PIX_W-1:0] o_pixel;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= ned_pkg::RST_THRESHOLD;
			width_q  <= ned_pkg::RST_WIDTH;
			height_q <= ned_pkg::RST_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ned_pkg::REG_THRESHOLD: thr_q <= cfg_data[ned_pkg::THR_W-1:0];
				ned_pkg::REG_WIDTH:     width_q <= cfg_data[ned_pkg::CFG_WIDTH_W-1:0];
				ned_pkg::REG_HEIGHT:    height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ned_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser[0]),
		.in_pixel   (s_tdata),
		.width_cfg  (width_q),
		.height_cfg (height_q),
		.q_item     (f_item),
		.q_valid    (f_valid),
		.q_ready    (f_ready)
	);

	ned_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (f_valid),
		.s_ready (f_ready),
		.s_item  (f_item),
		.m_valid (b_valid),
		.m_ready (b_ready),
		.m_item  (b_item)
	);

	ned_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_item    (b_item),
		.threshold (thr_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_edge  (o_edge),
		.out_pixel (o_pixel),
		.out_last  (o_last)
	);

	assign m_tdata = {7'd0, o_pixel, o_edge};
	assign m_tlast = o_last;

endmodule
`default_nettype wire

[bench/ned_checker.sv]
// ----------------------------------------------------------------------------
// ned_checker
// Watches the pixel, result and configuration channels of the edge detector,
// predicts every result from its own copy of the line stores and window, and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module ned_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [23:0] s_tdata,
	input  wire  [0:0]  s_tuser,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [31:0] m_tdata,
	input  wire         m_tlast,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	output int          errors,
	output int          awaited,
	output int          n_results,
	output int          n_edges
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = ned_pkg::DEF_MAX_WIDTH;

	typedef struct {
		logic                      edge_found;
		logic [ned_pkg::PIX_W-1:0] out_pixel;
		logic                      last_of_frame;
	} answer_t;

	answer_t answer_q[$];

	logic [ned_pkg::THR_W-1:0]        threshold;
	logic [ned_pkg::CFG_WIDTH_W-1:0]  width_reg;
	logic [ned_pkg::CFG_HEIGHT_W-1:0] height_reg;
	logic [ned_pkg::PIX_W-1:0]        upper_line[STORE_DEPTH];
	logic [ned_pkg::PIX_W-1:0]        middle_line[STORE_DEPTH];
	logic [ned_pkg::PIX_W-1:0]        win[3][3];
	int                               col_pos;
	int                               row_pos;
	int                               backlog;

	// Largest channel difference between two pixels.
	function automatic int channel_distance(logic [ned_pkg::PIX_W-1:0] a,
		logic [ned_pkg::PIX_W-1:0] b);
		int d;
		int m;
		m = 0;
		for (int c = 0; c < 3; c++) begin
			d = int'(a[c*8 +: 8]) - int'(b[c*8 +: 8]);
			if (d < 0) d = -d;
			if (d > m) m = d;
		end
		return m;
	endfunction

	// Shift one new column into the window, optionally updating the line stores.
	task automatic slide_window(int c, logic [ned_pkg::PIX_W-1:0] bottom, bit update_lines);
		int idx;
		logic [ned_pkg::PIX_W-1:0] up;
		logic [ned_pkg::PIX_W-1:0] mid;
		idx = c % STORE_DEPTH;
		up = upper_line[idx];
		mid = middle_line[idx];
		if (update_lines) begin
			upper_line[idx] = mid;
			middle_line[idx] = bottom;
		end
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = bottom;
	endtask

	// Classify the center pixel of the window for frame position pos.
	task automatic classify_center(longint pos, int w, int h);
		int pr;
		int pc;
		bit ok_row[3];
		bit ok_col[3];
		answer_t a;
		pr = int'(pos / w);
		pc = int'(pos % w);
		ok_row[0] = pr >= 1;
		ok_row[1] = 1'b1;
		ok_row[2] = pr + 1 < h;
		ok_col[0] = pc >= 1;
		ok_col[1] = 1'b1;
		ok_col[2] = pc + 1 < w;
		a.edge_found = 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (ok_row[i] && ok_col[j] &&
					channel_distance(win[1][1], win[i][j]) > int'(threshold))
					a.edge_found = 1'b1;
		a.out_pixel = a.edge_found ? ned_pkg::BLACK_PIXEL : ned_pkg::WHITE_PIXEL;
		a.last_of_frame = (pos == longint'(w) * h - 1);
		answer_q.push_back(a);
	endtask

	// Frame position of the oldest pixel still waiting for its result.
	function automatic longint oldest_position(int w, int h);
		longint f;
		longint a;
		f = longint'(w) * h;
		a = (longint'(row_pos) * w + col_pos) % f;
		return (a + f - (backlog % f)) % f;
	endfunction

	// Advance the prediction by one accepted input item.
	task automatic predict_item(logic cmd, logic [ned_pkg::PIX_W-1:0] pix);
		int w;
		int h;
		longint pos;
		w = (width_reg == 0) ? 1 : (width_reg > ned_pkg::DEF_MAX_WIDTH) ?
			ned_pkg::DEF_MAX_WIDTH : int'(width_reg);
		h = (height_reg == 0) ? 1 : int'(height_reg);
		if (cmd == ned_pkg::CMD_PIXEL) begin
			slide_window(col_pos, pix, 1'b1);
			if (col_pos + 1 >= w) begin
				col_pos = 0;
				row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
			end else begin
				col_pos++;
			end
			backlog++;
			if (backlog > w + 1) begin
				classify_center(oldest_position(w, h), w, h);
				backlog = w + 1;
			end
		end else if (backlog != 0) begin
			pos = oldest_position(w, h);
			slide_window(int'((pos % w + 1) % w), '0, 1'b0);
			classify_center(pos, w, h);
			backlog--;
		end
	endtask

	// Track configuration, predict on input transfers, compare result transfers.
	always @(posedge clk or negedge arst_n) begin
		answer_t exp_a;
		if (!arst_n) begin
			threshold = ned_pkg::RST_THRESHOLD;
			width_reg = ned_pkg::RST_WIDTH;
			height_reg = ned_pkg::RST_HEIGHT;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win[r][c] = '0;
			col_pos = 0;
			row_pos = 0;
			backlog = 0;
			answer_q.delete();
			errors = 0;
			awaited = 0;
			n_results = 0;
			n_edges = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ned_pkg::REG_THRESHOLD: threshold = cfg_data[ned_pkg::THR_W-1:0];
					ned_pkg::REG_WIDTH: width_reg = cfg_data[ned_pkg::CFG_WIDTH_W-1:0];
					ned_pkg::REG_HEIGHT: height_reg = cfg_data[ned_pkg::CFG_HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_item(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready) begin
				n_results++;
				if (answer_q.size() == 0) begin
					$error("result transfer with no prediction waiting: tdata=%h tlast=%b",
						m_tdata, m_tlast);
					errors++;
				end else begin
					exp_a = answer_q.pop_front();
					if (exp_a.edge_found) n_edges++;
					if (m_tdata[0] !== exp_a.edge_found) begin
						$error("edge_found expected %b actual %b", exp_a.edge_found, m_tdata[0]);
						errors++;
					end
					if (m_tdata[24:1] !== exp_a.out_pixel) begin
						$error("out_pixel expected %h actual %h", exp_a.out_pixel, m_tdata[24:1]);
						errors++;
					end
					if (m_tlast !== exp_a.last_of_frame) begin
						$error("last_of_frame expected %b actual %b", exp_a.last_of_frame, m_tlast);
						errors++;
					end
				end
			end
			awaited = answer_q.size();
		end
	end

endmodule
`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives whole frames of RGB pixels, each followed by the flushes that drain
// it, across many geometries and thresholds, with random idling on both
// sides and one long back-end stall; the checker judges every result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_GOAL = 950;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int errors;
	int awaited;
	int n_results;
	int n_edges;
	int n_items;
	int n_frames;
	bit quiet;
	bit hold_req;
	bit hold_done;

	neighborhood_edge_detect_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ned_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors), .awaited(awaited), .n_results(n_results), .n_edges(n_edges)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Safety net against a hung handshake.
	initial begin
		#2_000_000;
		$display("timeout waiting for transfers");
		$display("RESULT: ERROR");
		$finish;
	end

	// Result-side back pressure: random bursts, plus one long hold on request
	// that starts once results are due, so the block fills and stalls its input.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done && awaited != 0) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Write one register; the caller lowers cfg_valid after the last write.
	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
		end
		@(posedge clk);
	endtask

	// Offer one input item, with an occasional idle burst ahead of it.
	task automatic send_item(logic cmd, logic [23:0] pix);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= pix;
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		@(posedge clk);
		n_items++;
	endtask

	// Pixel content: 0 noise, 1 gentle gradient around a base, 2 extremes.
	function automatic logic [23:0] make_pixel(int style, logic [23:0] base);
		logic [23:0] p;
		case (style)
			0: p = 24'($urandom);
			1: begin
				p[23:16] = base[23:16] + 8'($urandom_range(0, 24));
				p[15:8] = base[15:8] + 8'($urandom_range(0, 24));
				p[7:0] = base[7:0] + 8'($urandom_range(0, 24));
			end
			default: begin
				case ($urandom_range(0, 2))
					0: p = ned_pkg::BLACK_PIXEL;
					1: p = ned_pkg::WHITE_PIXEL;
					default: p = 24'($urandom);
				endcase
			end
		endcase
		return p;
	endfunction

	// Configure, stream one whole frame, drain it, and wait for the block to settle.
	task automatic run_frame(int thr, int w, int h, int style, bit extra_flush);
		int we;
		int he;
		logic [23:0] base;
		we = (w == 0) ? 1 : (w > ned_pkg::DEF_MAX_WIDTH) ? ned_pkg::DEF_MAX_WIDTH : w;
		he = (h == 0) ? 1 : h;
		base = 24'($urandom);
		write_reg(ned_pkg::REG_THRESHOLD, 16'(thr));
		write_reg(ned_pkg::REG_WIDTH, 16'(w));
		write_reg(ned_pkg::REG_HEIGHT, 16'(h));
		cfg_valid <= 1'b0;
		for (int i = 0; i < we * he; i++)
			send_item(ned_pkg::CMD_PIXEL, make_pixel(style, base));
		for (int i = 0; i <= we; i++)
			send_item(ned_pkg::CMD_FLUSH, 24'($urandom));
		if (extra_flush)
			send_item(ned_pkg::CMD_FLUSH, 24'($urandom));
		s_tvalid <= 1'b0;
		do @(negedge clk); while (awaited != 0);
		repeat (12) @(posedge clk);
		n_frames++;
	endtask

	// Stimulus and verdict.
	initial begin
		int goal;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ned_pkg::CMD_PIXEL;
		cfg_valid = 1'b0;
		cfg_index = ned_pkg::REG_THRESHOLD;
		cfg_data = '0;
		n_items = 0;
		n_frames = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: flush with nothing pending, extreme pixels, edge disable,
		// width zero and height zero.
		send_item(ned_pkg::CMD_FLUSH, ned_pkg::WHITE_PIXEL);
		s_tvalid <= 1'b0;
		repeat (12) @(posedge clk);
		run_frame(0, 3, 3, 2, 1'b1);
		run_frame(255, 3, 2, 2, 1'b0);
		run_frame(10, 0, 2, 1, 1'b0);
		run_frame(10, 4, 0, 1, 1'b0);

		// A wider frame under a long result-side stall.
		hold_req = 1'b1;
		run_frame(20, 40, 4, 1, 1'b0);

		// Random frames, mostly small; the final stretch runs without idling.
		goal = ITEM_GOAL;
		while (n_items < goal) begin
			if (goal - n_items < 150) quiet = 1'b1;
			run_frame(($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? 255 : 0)
					: $urandom_range(0, 40),
				$urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(0, 2),
				$urandom_range(0, 3) == 0);
		end

		$display("Covered %0d frames and %0d input items; %0d results checked, %0d edges.",
			n_frames, n_items, n_results, n_edges);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
hdl/ned_pkg.sv
hdl/ned_front.sv
hdl/ned_queue.sv
hdl/ned_back.sv
hdl/neighborhood_edge_detect_core.sv
bench/ned_checker.sv
bench/tb.sv
